### design/grehp_pkg.sv
// ----------------------------------------------------------------------------
// GRE header parser package
// Shared result type and flag bit positions for the GRE header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package grehp_pkg;

  // flag word bit positions
  localparam int unsigned FlagCBit = 15;
  localparam int unsigned FlagRBit = 14;
  localparam int unsigned FlagKBit = 13;
  localparam int unsigned FlagSBit = 12;
  localparam int unsigned FlagABit = 7;
  localparam int unsigned VerWidth = 3;

  localparam logic [15:0] MatchProtocolReset = 16'h0800;

  typedef struct packed {
    logic                status;
    logic [15:0]         header_length;
    logic [15:0]         flag_word;
    logic [15:0]         protocol_type;
    logic [VerWidth-1:0] version_number;
    logic [15:0]         checksum_word;
    logic [15:0]         route_offset;
    logic [31:0]         key_word;
    logic [31:0]         sequence_word;
    logic [31:0]         ack_word;
    logic                protocol_match;
  } grehp_result_t;

endpackage

`default_nettype wire

### design/grehp_parser.sv
// ----------------------------------------------------------------------------
// GRE header parser byte engine
// Updates the per-packet parse state on every accepted byte until the header
// is complete and forms the result on the marked final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module grehp_parser (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   byte_valid,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  input  wire logic [15:0]            match_protocol,
  output      logic                   res_valid,
  output      grehp_pkg::grehp_result_t res_data
);

  localparam logic [2:0] PH_FIXED = 3'd0;
  localparam logic [2:0] PH_CSUM  = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_SEQ   = 3'd3;
  localparam logic [2:0] PH_ACK   = 3'd4;
  localparam logic [2:0] PH_RHDR  = 3'd5;
  localparam logic [2:0] PH_RBODY = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  logic [2:0]  phase_r,  phase_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic [1:0]  idx_r,    idx_nxt;
  logic [15:0] flags_r,  flags_nxt;
  logic [15:0] proto_r,  proto_nxt;
  logic [15:0] csum_r,   csum_nxt;
  logic [15:0] offs_r,   offs_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [31:0] seq_r,    seq_nxt;
  logic [31:0] ack_r,    ack_nxt;
  logic [7:0]  rleft_r,  rleft_nxt;
  logic        fin_r,    fin_nxt;

  // first optional field present after phase ph, or DONE
  function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic [15:0] fl);
    logic [7:0] pres;
    logic [2:0] nx;
    logic       found;
    pres = '0;
    pres[PH_CSUM] = fl[grehp_pkg::FlagCBit] | fl[grehp_pkg::FlagRBit];
    pres[PH_KEY]  = fl[grehp_pkg::FlagKBit];
    pres[PH_SEQ]  = fl[grehp_pkg::FlagSBit];
    pres[PH_ACK]  = fl[grehp_pkg::FlagABit];
    pres[PH_RHDR] = fl[grehp_pkg::FlagRBit];
    nx    = PH_DONE;
    found = 1'b0;
    for (int j = 1; j < 6; j++) begin
      if (!found && (3'(j) > ph) && pres[j]) begin
        nx    = 3'(j);
        found = 1'b1;
      end
    end
    return nx;
  endfunction

  always_comb begin
    logic       eof;
    logic       step;
    logic [2:0] nx;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    flags_nxt = flags_r;
    proto_nxt = proto_r;
    csum_nxt  = csum_r;
    offs_nxt  = offs_r;
    key_nxt   = key_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    rleft_nxt = rleft_r;
    fin_nxt   = fin_r;
    eof       = (idx_r == 2'd3);
    step      = 1'b0;
    nx        = PH_DONE;
    res_valid = 1'b0;
    res_data  = '0;

    if (byte_valid) begin
      if (!fin_r) begin
        if (cnt_r != 16'hFFFF) begin
          cnt_nxt = cnt_r + 16'd1;
        end
        case (phase_r)
          PH_FIXED: begin
            if (!idx_r[1]) flags_nxt = {flags_r[7:0], data_byte};
            else           proto_nxt = {proto_r[7:0], data_byte};
            step = 1'b1;
          end
          PH_CSUM: begin
            if (!idx_r[1]) csum_nxt = {csum_r[7:0], data_byte};
            else           offs_nxt = {offs_r[7:0], data_byte};
            step = 1'b1;
          end
          PH_KEY: begin
            key_nxt = {key_r[23:0], data_byte};
            step    = 1'b1;
          end
          PH_SEQ: begin
            seq_nxt = {seq_r[23:0], data_byte};
            step    = 1'b1;
          end
          PH_ACK: begin
            ack_nxt = {ack_r[23:0], data_byte};
            step    = 1'b1;
          end
          PH_RHDR: begin
            if (eof) begin
              idx_nxt = 2'd0;
              if (data_byte == 8'd0) begin
                // null entry closes the route list
                phase_nxt = PH_DONE;
                fin_nxt   = 1'b1;
              end else begin
                rleft_nxt = data_byte;
                phase_nxt = PH_RBODY;
              end
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          PH_RBODY: begin
            rleft_nxt = rleft_r - 8'd1;
            if (rleft_r == 8'd1) begin
              phase_nxt = PH_RHDR;
              idx_nxt   = 2'd0;
            end
          end
          default: begin
            phase_nxt = PH_DONE;
            idx_nxt   = 2'd0;
            fin_nxt   = 1'b1;
          end
        endcase

        if (step) begin
          if (eof) begin
            nx        = next_phase(phase_r, flags_r);
            idx_nxt   = 2'd0;
            phase_nxt = nx;
            if (nx == PH_DONE) fin_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end

      if (last_byte) begin
        res_valid               = 1'b1;
        res_data.status         = !fin_nxt;
        res_data.header_length  = cnt_nxt;
        res_data.flag_word      = flags_nxt;
        res_data.protocol_type  = proto_nxt;
        res_data.version_number = flags_nxt[grehp_pkg::VerWidth-1:0];
        res_data.checksum_word  = csum_nxt;
        res_data.route_offset   = offs_nxt;
        res_data.key_word       = key_nxt;
        res_data.sequence_word  = seq_nxt;
        res_data.ack_word       = ack_nxt;
        res_data.protocol_match = fin_nxt && (proto_nxt == match_protocol);
        // packet over: back to the fixed header
        phase_nxt = PH_FIXED;
        cnt_nxt   = '0;
        idx_nxt   = '0;
        flags_nxt = '0;
        proto_nxt = '0;
        csum_nxt  = '0;
        offs_nxt  = '0;
        key_nxt   = '0;
        seq_nxt   = '0;
        ack_nxt   = '0;
        rleft_nxt = '0;
        fin_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED;
      cnt_r   <= '0;
      idx_r   <= '0;
      flags_r <= '0;
      proto_r <= '0;
      csum_r  <= '0;
      offs_r  <= '0;
      key_r   <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      rleft_r <= '0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      flags_r <= flags_nxt;
      proto_r <= proto_nxt;
      csum_r  <= csum_nxt;
      offs_r  <= offs_nxt;
      key_r   <= key_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      rleft_r <= rleft_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

### design/grehp_skid.sv
// ----------------------------------------------------------------------------
// GRE header parser result buffer
// Output register with one skid entry so a stalled receiver does not
// stall the byte stream until two results are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module grehp_skid (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire grehp_pkg::grehp_result_t push_data,
  output      logic                    can_push,
  output      logic                    out_valid,
  output      grehp_pkg::grehp_result_t out_data,
  input  wire logic                    out_ready
);

  logic                     out_valid_r,  out_valid_nxt;
  logic                     skid_valid_r, skid_valid_nxt;
  grehp_pkg::grehp_result_t out_data_r,   out_data_nxt;
  grehp_pkg::grehp_result_t skid_data_r,  skid_data_nxt;

  always_comb begin
    logic pop;
    pop            = out_valid_r && out_ready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // no push can arrive while the skid entry is full
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/gre_header_parser.sv
// ----------------------------------------------------------------------------
// GRE header parser
// Byte-wide GRE header parser with a configurable protocol match.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packet byte per transfer in tdata, tlast on the final byte.
//   out_* : one result per packet, sent after the tlast byte; tuser is the
//           truncated flag, tdata holds the parsed header fields.
//   cfg_* : write cfg_wr_data to the match protocol register while idle.
// Throughput is one byte per cycle while in_tready is high: the parse state
// is updated on each accepted byte. The result of the tlast byte is registered
// in the output register, or in the skid entry while that register is held.
// Reset clears the parse state and the result buffer and loads the match
// protocol with 0x0800.
// When the receiver stalls the pending result holds and a second result is
// kept in a skid entry; in_tready drops only once both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module gre_header_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,   // last_byte
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // [15:0] header_length, [31:16] flag_word, [47:32] protocol_type,
  // [50:48] version_number, [66:51] checksum_word, [82:67] route_offset,
  // [114:83] key_word, [146:115] sequence_word, [178:147] ack_word,
  // [179] protocol_match, [183:180] zero
  output      logic [183:0] out_tdata,
  output      logic         out_tuser,  // [0] status
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data
);

  logic [15:0]              match_protocol_r;
  logic                     in_accept;
  logic                     res_valid;
  logic                     can_push;
  grehp_pkg::grehp_result_t res_data;
  grehp_pkg::grehp_result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_protocol_r <= grehp_pkg::MatchProtocolReset;
    end else if (cfg_wr_en) begin
      match_protocol_r <= cfg_wr_data;
    end
  end

  assign in_tready = can_push;
  assign in_accept = in_tvalid && in_tready;

  grehp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_valid     (in_accept),
    .data_byte      (in_tdata),
    .last_byte      (in_tlast),
    .match_protocol (match_protocol_r),
    .res_valid      (res_valid),
    .res_data       (res_data)
  );

  grehp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {4'b0000,
                      out_res.protocol_match,
                      out_res.ack_word,
                      out_res.sequence_word,
                      out_res.key_word,
                      out_res.route_offset,
                      out_res.checksum_word,
                      out_res.version_number,
                      out_res.protocol_type,
                      out_res.flag_word,
                      out_res.header_length};

`ifndef SYNTHESIS
  // input only blocks when both result slots are occupied
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // a tlast byte always leaves a result offered next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("no result after final byte");

  // truncated headers never report a protocol match
  a_trunc_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tdata[179])
    else $error("protocol match on truncated header");

  // version is the low bits of the flag word
  a_version_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[50:48] == out_tdata[18:16]))
    else $error("version field disagrees with flag word");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// GRE header parser testbench
// Streams GRE packets into the parser one byte per transfer and predicts each
// result from a cycle-free model of the parse held in the bench. Directed
// packets cover minimal, fully optioned, source-routed, truncated and
// long-route headers; random packets, mostly well formed, follow under several
// mixes of sender idling and receiver stalls, each with its own match value.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;

  typedef enum logic [3:0] {
    StFixed, StCsum, StKey, StSeq, StAck, StRouteHdr, StRouteBody, StDone
  } gre_stage_e;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = 16'h0000;

  gre_header_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // parse state mirrored from the block
  gre_stage_e  p_stage;
  logic [15:0] p_bytes;
  logic [1:0]  p_idx;
  logic [15:0] p_flags;
  logic [15:0] p_proto;
  logic [15:0] p_csum;
  logic [15:0] p_offset;
  logic [31:0] p_key;
  logic [31:0] p_seq;
  logic [31:0] p_ack;
  logic [7:0]  p_route_left;
  logic        p_hdr_done;
  logic [15:0] p_match;

  grehp_pkg::grehp_result_t pending_headers[$];
  grehp_pkg::grehp_result_t want_hdr;
  grehp_pkg::grehp_result_t seen_hdr;
  logic [7:0]               pkt_bytes[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int pkts_sent = 0;
  int bytes_sent = 0;
  int headers_checked = 0;
  int cycles = 0;

  function automatic void clear_parse_state();
    p_stage      = StFixed;
    p_bytes      = '0;
    p_idx        = '0;
    p_flags      = '0;
    p_proto      = '0;
    p_csum       = '0;
    p_offset     = '0;
    p_key        = '0;
    p_seq        = '0;
    p_ack        = '0;
    p_route_left = '0;
    p_hdr_done   = 1'b0;
  endfunction

  function automatic void finish_hdr();
    p_stage    = StDone;
    p_idx      = '0;
    p_hdr_done = 1'b1;
  endfunction

  // one accepted byte; on the marked byte the parsed header is queued
  function automatic void gre_parse_byte(logic [7:0] b, logic last);
    logic                     eof;
    logic                     step_on;
    logic                     present;
    int                       nx;
    grehp_pkg::grehp_result_t hdr;
    if (!p_hdr_done) begin
      eof     = (p_idx == 2'd3);
      step_on = 1'b1;
      if (p_bytes != 16'hFFFF) p_bytes++;
      case (p_stage)
        StFixed: begin
          if (p_idx < 2) p_flags = {p_flags[7:0], b};
          else p_proto = {p_proto[7:0], b};
        end
        StCsum: begin
          if (p_idx < 2) p_csum = {p_csum[7:0], b};
          else p_offset = {p_offset[7:0], b};
        end
        StKey: p_key = {p_key[23:0], b};
        StSeq: p_seq = {p_seq[23:0], b};
        StAck: p_ack = {p_ack[23:0], b};
        StRouteHdr: begin
          step_on = 1'b0;
          if (!eof) begin
            p_idx++;
          end else if (b == 8'h00) begin
            finish_hdr();   // null entry closes the route list
          end else begin
            p_route_left = b;
            p_stage      = StRouteBody;
            p_idx        = '0;
          end
        end
        StRouteBody: begin
          step_on = 1'b0;
          p_route_left--;
          if (p_route_left == 8'd0) begin
            p_stage = StRouteHdr;
            p_idx   = '0;
          end
        end
        default: begin
          step_on = 1'b0;
          finish_hdr();
        end
      endcase
      if (step_on && !eof) begin
        p_idx++;
      end else if (step_on) begin
        // skip optional fields whose flag is clear
        nx = int'(p_stage) + 1;
        present = 1'b0;
        while (nx < int'(StRouteBody) && !present) begin
          case (nx)
            int'(StCsum): present = p_flags[grehp_pkg::FlagCBit] |
                                    p_flags[grehp_pkg::FlagRBit];
            int'(StKey):  present = p_flags[grehp_pkg::FlagKBit];
            int'(StSeq):  present = p_flags[grehp_pkg::FlagSBit];
            int'(StAck):  present = p_flags[grehp_pkg::FlagABit];
            default:      present = p_flags[grehp_pkg::FlagRBit];
          endcase
          if (!present) nx++;
        end
        p_idx = '0;
        if (nx >= int'(StRouteBody)) finish_hdr();
        else p_stage = gre_stage_e'(nx);
      end
    end
    if (last) begin
      hdr.status         = ~p_hdr_done;
      hdr.header_length  = p_bytes;
      hdr.flag_word      = p_flags;
      hdr.protocol_type  = p_proto;
      hdr.version_number = p_flags[grehp_pkg::VerWidth-1:0];
      hdr.checksum_word  = p_csum;
      hdr.route_offset   = p_offset;
      hdr.key_word       = p_key;
      hdr.sequence_word  = p_seq;
      hdr.ack_word       = p_ack;
      hdr.protocol_match = p_hdr_done && (p_proto == p_match);
      pending_headers.push_back(hdr);
      clear_parse_state();
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) gre_parse_byte(in_tdata, in_tlast);
  end

  function automatic void bad_field(string name, logic [31:0] want, logic [31:0] seen);
    $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_headers.size() == 0) begin
        $error("result transfer with no packet pending");
        mismatches++;
      end else begin
        want_hdr = pending_headers.pop_front();
        seen_hdr.status         = out_tuser;
        seen_hdr.header_length  = out_tdata[15:0];
        seen_hdr.flag_word      = out_tdata[31:16];
        seen_hdr.protocol_type  = out_tdata[47:32];
        seen_hdr.version_number = out_tdata[50:48];
        seen_hdr.checksum_word  = out_tdata[66:51];
        seen_hdr.route_offset   = out_tdata[82:67];
        seen_hdr.key_word       = out_tdata[114:83];
        seen_hdr.sequence_word  = out_tdata[146:115];
        seen_hdr.ack_word       = out_tdata[178:147];
        seen_hdr.protocol_match = out_tdata[179];
        headers_checked++;
        if (seen_hdr.status !== want_hdr.status)
          bad_field("status", want_hdr.status, seen_hdr.status);
        if (seen_hdr.header_length !== want_hdr.header_length)
          bad_field("header_length", want_hdr.header_length, seen_hdr.header_length);
        if (seen_hdr.flag_word !== want_hdr.flag_word)
          bad_field("flag_word", want_hdr.flag_word, seen_hdr.flag_word);
        if (seen_hdr.protocol_type !== want_hdr.protocol_type)
          bad_field("protocol_type", want_hdr.protocol_type, seen_hdr.protocol_type);
        if (seen_hdr.version_number !== want_hdr.version_number)
          bad_field("version_number", want_hdr.version_number, seen_hdr.version_number);
        if (seen_hdr.checksum_word !== want_hdr.checksum_word)
          bad_field("checksum_word", want_hdr.checksum_word, seen_hdr.checksum_word);
        if (seen_hdr.route_offset !== want_hdr.route_offset)
          bad_field("route_offset", want_hdr.route_offset, seen_hdr.route_offset);
        if (seen_hdr.key_word !== want_hdr.key_word)
          bad_field("key_word", want_hdr.key_word, seen_hdr.key_word);
        if (seen_hdr.sequence_word !== want_hdr.sequence_word)
          bad_field("sequence_word", want_hdr.sequence_word, seen_hdr.sequence_word);
        if (seen_hdr.ack_word !== want_hdr.ack_word)
          bad_field("ack_word", want_hdr.ack_word, seen_hdr.ack_word);
        if (seen_hdr.protocol_match !== want_hdr.protocol_match)
          bad_field("protocol_match", want_hdr.protocol_match, seen_hdr.protocol_match);
        if (out_tdata[183:180] !== 4'h0)
          bad_field("tdata_pad", 32'h0, out_tdata[183:180]);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    bytes_sent += pkt_bytes.size();
    pkts_sent++;
    pkt_bytes.delete();
  endtask

  function automatic void push_bytes(logic [31:0] value, int n);
    for (int i = n - 1; i >= 0; i--) pkt_bytes.push_back(value[8*i +: 8]);
  endfunction

  function automatic void push_random(int n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endfunction

  // lets the last transfer drain before anything touches the config
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_match(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_match = value;
  endtask

  task automatic test_minimal_header();
    push_bytes(32'h0007_0800, 4);   // matches the reset protocol
    send_packet();
    push_bytes(32'hFF, 1);          // ends inside the flag word
    send_packet();
    wait_idle();
  endtask

  task automatic test_all_options();
    write_match(16'hFFFF);
    push_bytes(32'hB087_FFFF, 4);   // C, K, S, A, version 7
    push_bytes(32'hFFFF_0000, 4);
    push_bytes(32'hFFFF_FFFF, 4);
    push_bytes(32'h0000_0000, 4);
    push_bytes(32'h8000_0001, 4);
    push_bytes(32'h00FF, 2);        // trailing payload, ignored
    send_packet();
    wait_idle();
  endtask

  task automatic test_source_route();
    write_match(16'h0000);
    push_bytes(32'h4000_0000, 4);
    push_bytes(32'h1234_0004, 4);
    push_bytes(32'h0001_0201, 4);   // one entry, one body byte
    push_bytes(32'hAA, 1);
    push_bytes(32'h0000_0000, 4);   // null entry, still header
    push_bytes(32'h55, 1);
    send_packet();
    wait_idle();
  endtask

  task automatic test_truncated_field();
    push_bytes(32'h2000_1234, 4);
    push_bytes(32'hABCD, 2);        // key cut after two bytes
    send_packet();
    wait_idle();
  endtask

  task automatic test_long_route();
    push_bytes(32'h4000_6558, 4);
    push_random(4);
    push_random(3);
    push_bytes(32'hFF, 1);          // longest route entry body
    push_random(255);
    push_random(3);
    push_bytes(32'h0, 1);
    push_random(2);
    send_packet();
    wait_idle();
  endtask

  task automatic gen_random_packet();
    logic [15:0] flags;
    logic [15:0] proto;
    int          kind;
    int          keep;
    int          len;
    kind = $urandom_range(99);
    if (kind < 8) begin
      push_random($urandom_range(24, 1));   // noise
      return;
    end
    flags = 16'($urandom);
    case ($urandom_range(3))
      0, 1:    proto = p_match;
      2:       proto = p_match ^ (16'h1 << $urandom_range(15));
      default: proto = 16'($urandom);
    endcase
    push_bytes({flags, proto}, 4);
    if (flags[grehp_pkg::FlagCBit] | flags[grehp_pkg::FlagRBit]) push_random(4);
    if (flags[grehp_pkg::FlagKBit]) push_random(4);
    if (flags[grehp_pkg::FlagSBit]) push_random(4);
    if (flags[grehp_pkg::FlagABit]) push_random(4);
    if (flags[grehp_pkg::FlagRBit]) begin
      repeat ($urandom_range(3)) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(255, 1) : $urandom_range(6, 1);
        push_random(3);
        push_bytes(len, 1);
        push_random(len);
      end
      push_random(3);
      push_bytes(32'h0, 1);
    end
    push_random($urandom_range(4));
    if (kind < 28) begin
      keep = $urandom_range(pkt_bytes.size(), 1);
      while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [15:0] match_value, input int budget);
    int start_bytes;
    write_match(match_value);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    start_bytes    = bytes_sent;
    while (bytes_sent - start_bytes < budget) begin
      gen_random_packet();
      send_packet();
    end
    wait_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    clear_parse_state();
    p_match = grehp_pkg::MatchProtocolReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_minimal_header();
    test_all_options();
    test_source_route();
    test_truncated_field();
    test_long_route();
    test_random_traffic(0, 0, 16'h0800, 220);
    test_random_traffic(47, 0, 16'h0000, 220);
    test_random_traffic(0, 47, 16'hFFFF, 220);
    test_random_traffic(15, 15, 16'($urandom), 220);

    repeat (10) @(posedge clk);
    $display("summary: %0d packets, %0d bytes sent, %0d headers checked",
             pkts_sent, bytes_sent, headers_checked);
    $display("summary: directed option/route/truncation/long-route cases, then random");
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
design/grehp_pkg.sv
design/grehp_parser.sv
design/grehp_skid.sv
design/gre_header_parser.sv
tb/tb.sv
